// File: rtl/core/fgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgd_pkg: shared types for the four group dimmer level update block
// Request and result payloads, command modes and per-group update control.
// ----------------------------------------------------------------------------
package fgd_pkg;

  localparam int unsigned NumGroups = 4;
  localparam int unsigned LevelW    = 7;
  localparam int unsigned StepW     = 8;

  localparam logic [LevelW-1:0] LevelMax = 7'h7f;
  localparam logic [LevelW-1:0] LevelMin = 7'h00;

  typedef enum logic [1:0] {
    MODE_SET_MASK = 2'd0,
    MODE_ADD_MASK = 2'd1,
    MODE_ADD_ONE  = 2'd2,
    MODE_NOP      = 2'd3
  } fgd_mode_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic [1:0]              group;
    logic signed [StepW-1:0] value;
  } fgd_req_t;

  typedef struct packed {
    logic [LevelW-1:0] level_g3;
    logic [LevelW-1:0] level_g2;
    logic [LevelW-1:0] level_g1;
    logic [LevelW-1:0] level_g0;
  } fgd_result_t;

  typedef struct packed {
    logic             wr_set;
    logic             wr_add;
    logic [StepW-1:0] value;
  } fgd_lane_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/fgd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgd_lane: next level of one light group
// Loads the low seven bits of the value, or adds the signed step with
// clamping to the level range, or keeps the level.
// ----------------------------------------------------------------------------
module fgd_lane (
  input  logic [fgd_pkg::LevelW-1:0] level_i,
  input  fgd_pkg::fgd_lane_ctrl_t    ctrl_i,
  output logic [fgd_pkg::LevelW-1:0] level_o
);
  import fgd_pkg::*;

  logic [StepW:0] sum;

  assign sum = {2'b00, level_i} + {ctrl_i.value[StepW-1], ctrl_i.value};

  always_comb begin
    priority if (ctrl_i.wr_set) begin
      level_o = ctrl_i.value[LevelW-1:0];
    end else if (ctrl_i.wr_add) begin
      priority if (sum[StepW]) begin
        level_o = LevelMin;
      end else if (sum[StepW-1]) begin
        level_o = LevelMax;
      end else begin
        level_o = sum[LevelW-1:0];
      end
    end else begin
      level_o = level_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/four_group_dimmer_level_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_group_dimmer_level_update: brightness levels of four light groups
// A request is taken whenever start is high; busy never rises, so one request
// per cycle is sustained. The request is registered and applied to the four
// levels in the next cycle. The four new levels are then on result_o with
// strobe high for one cycle. The receiver cannot stall results. The group
// mask is written through the cfg channel, which is always ready, and must
// only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module four_group_dimmer_level_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fgd_pkg::fgd_req_t   cmd_i,
  output logic                strobe,
  output fgd_pkg::fgd_result_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_data_i
);
  import fgd_pkg::*;

  logic                 cmd_valid_q;
  fgd_req_t             cmd_q;
  logic [NumGroups-1:0] group_select_q;
  logic [LevelW-1:0]    levels_q [NumGroups];
  logic [LevelW-1:0]    levels_d [NumGroups];
  fgd_lane_ctrl_t       lane_ctrl [NumGroups];
  logic                 strobe_q;
  fgd_result_t          result_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      lane_ctrl[i].value  = cmd_q.value;
      lane_ctrl[i].wr_set = 1'b0;
      lane_ctrl[i].wr_add = 1'b0;
      if (cmd_valid_q) begin
        unique case (fgd_mode_e'(cmd_q.mode))
          MODE_SET_MASK: lane_ctrl[i].wr_set = group_select_q[i];
          MODE_ADD_MASK: lane_ctrl[i].wr_add = group_select_q[i];
          MODE_ADD_ONE:  lane_ctrl[i].wr_add = (cmd_q.group == i[1:0]);
          MODE_NOP:      lane_ctrl[i].wr_add = 1'b0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < NumGroups; g++) begin : g_lane
    fgd_lane u_lane (
      .level_i (levels_q[g]),
      .ctrl_i  (lane_ctrl[g]),
      .level_o (levels_d[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q    <= 1'b0;
      group_select_q <= '0;
      strobe_q       <= 1'b0;
      for (int i = 0; i < NumGroups; i++) begin
        levels_q[i] <= '0;
      end
    end else begin
      cmd_valid_q <= start && !busy;
      strobe_q    <= cmd_valid_q;
      if (cfg_valid_i && cfg_ready_o) begin
        group_select_q <= cfg_data_i;
      end
      for (int i = 0; i < NumGroups; i++) begin
        levels_q[i] <= levels_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    if (cmd_valid_q) begin
      result_q.level_g0 <= levels_d[0];
      result_q.level_g1 <= levels_d[1];
      result_q.level_g2 <= levels_d[2];
      result_q.level_g3 <= levels_d[3];
    end
  end

  assign strobe   = strobe_q;
  assign result_o = result_q;

  // Every result strobe is preceded by an applied request.
  a_strobe_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(cmd_valid_q))
    else $error("result strobe without a request in flight");

  // Levels only move when a request is applied.
  a_levels_hold_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_q |=> ($stable(levels_q[0]) && $stable(levels_q[1]) &&
                      $stable(levels_q[2]) && $stable(levels_q[3])))
    else $error("levels changed without a request");

  // The unused mode leaves every level untouched.
  a_unused_mode_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && cmd_q.mode == MODE_NOP) |=>
      ($stable(levels_q[0]) && $stable(levels_q[1]) &&
       $stable(levels_q[2]) && $stable(levels_q[3])))
    else $error("unused mode changed a level");

  // The reported levels are the stored levels.
  a_result_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> (result_o.level_g0 == levels_q[0] && result_o.level_g1 == levels_q[1] &&
                result_o.level_g2 == levels_q[2] && result_o.level_g3 == levels_q[3]))
    else $error("result differs from stored levels");

endmodule
`default_nettype wire
